[sv/lpd_pkg.sv]
// Shared types and codes for the length-prefixed deframer.
// No dependencies; imported by every module of the block.
package lpd_pkg;

  // Length header bytes that fit the 32-bit frame length (LSB-first order)
  localparam int LEN_BYTES = 4;

  // Input transaction kinds
  localparam logic KIND_BYTE   = 1'b0;
  localparam logic KIND_RESUME = 1'b1;

  // Configuration register indexes
  localparam logic [0:0] CFG_MAX_LENGTH = 1'b0;
  localparam logic [0:0] CFG_MSB_FIRST  = 1'b1;

  localparam logic [31:0] MAX_LENGTH_RST = 32'd1048576;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_DISCARD = 2'd2
  } lpd_phase_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    logic [31:0] buffer_free;
  } lpd_in_t;

  typedef struct packed {
    logic        consumed;
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic        payload_last;
    logic        frame_discarded;
    logic        paused;
    logic [31:0] discard_count;
  } lpd_out_t;

  // Frame tracking state, excluding the header byte count
  typedef struct packed {
    lpd_phase_t  phase;
    logic        pause;
    logic [31:0] frame_length;
    logic [31:0] bytes_done;
    logic [31:0] discarded;
  } lpd_state_t;

endpackage

[sv/lpd_step.sv]
// Per-transaction next-state and result logic of the deframer.
// Depends on lpd_pkg. Purely combinational.
module lpd_step
  import lpd_pkg::*;
#(
  parameter int HEADER_BYTES = 4,
  parameter int CW           = 3
) (
  input  lpd_state_t  st,
  input  logic [CW-1:0] hcnt,
  input  lpd_in_t     item,
  input  logic [31:0] max_length,
  input  logic        msb_first,
  output lpd_state_t  st_nxt,
  output logic [CW-1:0] hcnt_nxt,
  output lpd_out_t    res
);

  logic [31:0]   len_base;
  logic [31:0]   len_asm;
  logic [1:0]    hpos;
  logic [CW-1:0] hcnt_inc;
  logic          hdr_done;
  logic [31:0]   done_inc;
  logic          done_end;
  logic [31:0]   disc_inc;
  logic [31:0]   dec_len;
  logic          dec_zero;
  logic          dec_over;
  logic          dec_fit;
  logic          run_dec;
  logic          f_consumed;
  logic          f_valid;
  logic          f_last;
  logic          f_disc;

  // Header assembly, counter increments and length-decision terms
  always_comb begin
    len_base = (hcnt == '0) ? 32'd0 : st.frame_length;
    hpos     = 2'(hcnt);
    if (msb_first) begin
      len_asm = {len_base[23:0], item.data_byte};
    end else if (32'(hcnt) < 32'(LEN_BYTES)) begin
      len_asm = len_base | (32'(item.data_byte) << {hpos, 3'b000});
    end else begin
      len_asm = len_base;
    end
    hcnt_inc = CW'(hcnt + CW'(1));
    hdr_done = 32'(hcnt_inc) >= 32'(HEADER_BYTES);
    done_inc = st.bytes_done + 32'd1;
    done_end = done_inc >= st.frame_length;
    disc_inc = st.discarded + 32'd1;
    dec_len  = (item.kind == KIND_RESUME) ? st.frame_length : len_asm;
    dec_zero = dec_len == 32'd0;
    dec_over = dec_len > max_length;
    dec_fit  = dec_len <= item.buffer_free;
  end

  // Next state
  always_comb begin
    st_nxt     = st;
    hcnt_nxt   = hcnt;
    run_dec    = 1'b0;
    f_consumed = 1'b0;
    f_valid    = 1'b0;
    f_last     = 1'b0;
    f_disc     = 1'b0;
    if (item.kind == KIND_RESUME) begin
      if (st.pause) begin
        st_nxt.pause = 1'b0;
        run_dec      = 1'b1;
      end
    end else if (!st.pause) begin
      f_consumed = 1'b1;
      unique case (st.phase)
        PH_PAYLOAD: begin
          f_valid          = 1'b1;
          st_nxt.bytes_done = done_inc;
          if (done_end) begin
            f_last            = 1'b1;
            st_nxt.phase      = PH_HEADER;
            st_nxt.bytes_done = '0;
          end
        end
        PH_DISCARD: begin
          st_nxt.bytes_done = done_inc;
          if (done_end) begin
            f_disc            = 1'b1;
            st_nxt.discarded  = disc_inc;
            st_nxt.phase      = PH_HEADER;
            st_nxt.bytes_done = '0;
          end
        end
        default: begin
          st_nxt.phase        = PH_HEADER;
          st_nxt.frame_length = len_asm;
          hcnt_nxt            = hcnt_inc;
          if (hdr_done) begin
            hcnt_nxt = CW'(HEADER_BYTES);
            run_dec  = 1'b1;
          end
        end
      endcase
    end

    // Length decision on a complete header, or on a resume while paused
    if (run_dec) begin
      priority if (dec_zero) begin
        f_disc            = 1'b1;
        st_nxt.discarded  = disc_inc;
        st_nxt.phase      = PH_HEADER;
        hcnt_nxt          = '0;
        st_nxt.bytes_done = '0;
      end else if (dec_over) begin
        st_nxt.phase      = PH_DISCARD;
        hcnt_nxt          = '0;
        st_nxt.bytes_done = '0;
      end else if (dec_fit) begin
        st_nxt.phase      = PH_PAYLOAD;
        hcnt_nxt          = '0;
        st_nxt.bytes_done = '0;
      end else begin
        st_nxt.pause = 1'b1;
      end
    end
  end

  // Result fields
  always_comb begin
    res.consumed        = f_consumed;
    res.payload_valid   = f_valid;
    res.payload_byte    = f_valid ? item.data_byte : 8'd0;
    res.payload_last    = f_last;
    res.frame_discarded = f_disc;
    res.paused          = st_nxt.pause;
    res.discard_count   = st_nxt.discarded;
  end

endmodule

[sv/length_prefixed_deframer.sv]
// Top level of the length-prefixed deframer: registers, handshakes, config.
// Depends on lpd_pkg and lpd_step.
//
// Usage:
//  - Input channel (in_valid/in_stall/in_data): one transaction per stream
//    byte (kind byte) or per resume notice (kind resume) with the current
//    free space of the receive buffer.
//  - Result channel (out_valid/out_stall/out_data): exactly one result per
//    input transaction, in order: consumed flag, payload byte with last
//    marker, discard pulse, pause flag and running discard count.
//  - Config port: cfg_we with cfg_index 0 writes max_length, index 1 writes
//    the header byte order. Write only while no transaction is in flight.
//  - Path: a taken input is held in the input register, passes through
//    the step and is registered in the result register.
//  - Throughput: one transaction per cycle unless out_stall holds the
//    result; the frame state updates in the single step between them.
//  - Reset (rst_n low, synchronous): both stages empty, header phase, not
//    paused, discard count zero, max_length 1048576, LSB-first header.
//  - Receiver stall: the result register holds; the input register drains
//    only when the result register frees, so in_stall rises once it is full.
module length_prefixed_deframer
  import lpd_pkg::*;
#(
  parameter int HEADER_BYTES = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  lpd_in_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output lpd_out_t    out_data
);

  localparam int CW = $clog2(HEADER_BYTES + 1);

  // Configuration
  logic [31:0] max_len_r;
  logic        msb_first_r;

  // Input stage
  logic        s1_valid_r;
  lpd_in_t     s1_item_r;

  // Frame state
  lpd_state_t    st_r;
  lpd_state_t    st_nxt;
  logic [CW-1:0] hcnt_r;
  logic [CW-1:0] hcnt_nxt;

  // Result stage
  logic        out_valid_r;
  lpd_out_t    out_data_r;
  lpd_out_t    res;

  logic        res_en;   // result register free to load
  logic        advance;  // input stage moves through the step
  logic        in_take;

  assign res_en   = !out_valid_r || !out_stall;
  assign advance  = s1_valid_r && res_en;
  assign in_stall = s1_valid_r && !res_en;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r   <= MAX_LENGTH_RST;
      msb_first_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAX_LENGTH: max_len_r   <= cfg_wdata;
        CFG_MSB_FIRST:  msb_first_r <= cfg_wdata[0];
        default:        max_len_r   <= max_len_r;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r <= in_data;
    end
  end

  lpd_step #(
    .HEADER_BYTES (HEADER_BYTES),
    .CW           (CW)
  ) u_step (
    .st         (st_r),
    .hcnt       (hcnt_r),
    .item       (s1_item_r),
    .max_length (max_len_r),
    .msb_first  (msb_first_r),
    .st_nxt     (st_nxt),
    .hcnt_nxt   (hcnt_nxt),
    .res        (res)
  );

  // Frame state commits as the transaction enters the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase        <= PH_HEADER;
      st_r.pause        <= 1'b0;
      st_r.frame_length <= '0;
      st_r.bytes_done   <= '0;
      st_r.discarded    <= '0;
      hcnt_r            <= '0;
    end else if (advance) begin
      st_r   <= st_nxt;
      hcnt_r <= hcnt_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_en) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[sv/lpd_checker.sv]
// Port-level checks for length_prefixed_deframer, bound to the top level.
// Depends on lpd_pkg.
module lpd_checker
  import lpd_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input lpd_out_t    out_data
);

  // Held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Input only backs up behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a held result");

  // A payload byte is always a consumed byte
  a_payload_consumed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.payload_valid |-> out_data.consumed)
    else $error("payload byte not consumed");

  // Last marker only on a payload byte
  a_last_on_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.payload_last |-> out_data.payload_valid)
    else $error("last marker without payload");

  // A payload byte never coincides with a discard or a pause
  a_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.payload_valid |->
      !out_data.frame_discarded && !out_data.paused)
    else $error("payload with discard or pause");

endmodule

bind length_prefixed_deframer lpd_checker u_lpd_checker (.*);

[sim/tb.sv]
// Self-checking testbench for length_prefixed_deframer: directed frames, then
// random framed traffic under several register settings and flow-control mixes.
// Depends on lpd_pkg and the length_prefixed_deframer RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lpd_pkg::*;

  // Longest run with nothing accepted on either channel before the run is
  // abandoned; the deliberate receiver hold-off is well inside this.
  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 200;
  localparam int PHASE_ITEMS = 88;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = CFG_MAX_LENGTH;
  logic [31:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  lpd_in_t     in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  lpd_out_t    out_data;

  length_prefixed_deframer #(
    .HEADER_BYTES(LEN_BYTES)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: register copies and frame tracking, at reset values.
  // Register copies only change while the block is idle, so the stimulus
  // generator reads them too.
  // ---------------------------------------------------------------------------
  logic [31:0] cfg_max_len = MAX_LENGTH_RST;
  logic        cfg_msb_first = 1'b0;

  lpd_phase_t  frame_phase = PH_HEADER;
  logic        waiting_space = 1'b0;
  int          hdr_count = 0;
  logic [31:0] frame_len = '0;
  logic [31:0] frame_done = '0;
  logic [31:0] discards = '0;

  lpd_in_t  queued_items[$];    // transactions waiting to be offered
  lpd_out_t pending_results[$]; // predicted results not yet seen

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int items_queued = 0;
  int holds_asked = 0;
  int holds_served = 0;
  int hold_left = 0;
  int results_seen = 0;
  int error_count = 0;
  int quiet_cycles = 0;

  // Length decision on a full header; 1 when it retires a zero-length frame.
  function automatic logic decide_length(logic [31:0] space);
    if (frame_len == 0) begin
      discards++;
      frame_phase = PH_HEADER;
      hdr_count = 0;
      frame_done = '0;
      return 1'b1;
    end
    if (frame_len > cfg_max_len) begin
      frame_phase = PH_DISCARD;
      hdr_count = 0;
      frame_done = '0;
    end else if (frame_len <= space) begin
      frame_phase = PH_PAYLOAD;
      hdr_count = 0;
      frame_done = '0;
    end else begin
      waiting_space = 1'b1; // header kept; a resume re-runs the decision
    end
    return 1'b0;
  endfunction

  // Advances the frame tracker by one transaction and returns its result.
  function automatic lpd_out_t deframe_result(lpd_in_t it);
    lpd_out_t r;
    r = '0;
    if (it.kind == KIND_RESUME) begin
      // resume outside a pause is ignored
      if (waiting_space) begin
        waiting_space = 1'b0;
        r.frame_discarded = decide_length(it.buffer_free);
      end
    end else if (!waiting_space) begin
      r.consumed = 1'b1;
      case (frame_phase)
        PH_PAYLOAD: begin
          r.payload_valid = 1'b1;
          r.payload_byte = it.data_byte;
          frame_done++;
          if (frame_done >= frame_len) begin
            r.payload_last = 1'b1;
            frame_phase = PH_HEADER;
            frame_done = '0;
          end
        end
        PH_DISCARD: begin
          frame_done++;
          if (frame_done >= frame_len) begin
            discards++;
            r.frame_discarded = 1'b1;
            frame_phase = PH_HEADER;
            frame_done = '0;
          end
        end
        default: begin
          if (hdr_count == 0) frame_len = '0;
          if (cfg_msb_first) begin
            frame_len = {frame_len[23:0], it.data_byte};
          end else if (hdr_count < 4) begin
            frame_len |= 32'(it.data_byte) << (8 * hdr_count);
          end
          hdr_count++;
          if (hdr_count >= LEN_BYTES) begin
            hdr_count = LEN_BYTES;
            r.frame_discarded = decide_length(it.buffer_free);
          end
        end
      endcase
    end
    r.paused = waiting_space;
    r.discard_count = discards;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Input driver: offers queued transactions, holds a stalled one unchanged,
  // and predicts the result of each transaction as it is taken.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
    end else begin
      if (in_valid && !in_stall) pending_results.push_back(deframe_result(in_data));
      if (!in_valid || !in_stall) begin
        if (queued_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data <= queued_items.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic report_mismatch(string msg);
    $display("mismatch at result %0d: %s", results_seen, msg);
    error_count++;
  endtask

  task automatic check_field(string field, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h, expected %0h", field, got, want));
  endtask

  // ---------------------------------------------------------------------------
  // Result monitor and receiver stall. A hold-off request from the stimulus
  // process is served here as a long stretch of stall, counted locally.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_monitor
    lpd_out_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result with no transaction outstanding");
        end else begin
          want = pending_results.pop_front();
          check_field("consumed", 32'(out_data.consumed), 32'(want.consumed));
          check_field("payload_valid", 32'(out_data.payload_valid),
                      32'(want.payload_valid));
          check_field("payload_byte", 32'(out_data.payload_byte),
                      32'(want.payload_byte));
          check_field("payload_last", 32'(out_data.payload_last),
                      32'(want.payload_last));
          check_field("frame_discarded", 32'(out_data.frame_discarded),
                      32'(want.frame_discarded));
          check_field("paused", 32'(out_data.paused), 32'(want.paused));
          check_field("discard_count", out_data.discard_count, want.discard_count);
        end
        results_seen++;
      end
      if (holds_served != holds_asked) begin
        holds_served <= holds_asked;
        hold_left <= HOLD_CYCLES;
        out_stall <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Watchdog: gives up after a long stretch with no transaction on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
      $display("length_prefixed_deframer verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  // counts: 0 for transactions the block simply refuses or ignores
  task automatic push_item(logic kind, logic [7:0] data, logic [31:0] space, int counts);
    lpd_in_t it;
    it.kind = kind;
    it.data_byte = data;
    it.buffer_free = space;
    queued_items.push_back(it);
    items_queued += counts;
  endtask

  function automatic logic [31:0] fit_space(logic [31:0] len);
    case ($urandom_range(3))
      0: return len;           // exactly enough
      1: return 32'hFFFF_FFFF;
      2: return len + $urandom_range(64);
      default: return $urandom() | len;
    endcase
  endfunction

  function automatic logic [31:0] short_space(logic [31:0] len);
    if (len == 0 || $urandom_range(3) == 0) return '0;
    return $urandom_range(len - 1);
  endfunction

  // One whole frame: header in the current byte order, then whatever the
  // length decision calls for. A frame that pauses gets `refused` refused
  // bytes per pause stretch and `retries` resumes with too little space.
  task automatic push_frame(logic [31:0] len, logic [31:0] space, int refused, int retries);
    int shift;
    for (int i = 0; i < LEN_BYTES; i++) begin
      shift = cfg_msb_first ? 8 * (LEN_BYTES - 1 - i) : 8 * i;
      push_item(KIND_BYTE, 8'(len >> shift), (i == LEN_BYTES - 1) ? space : $urandom(), 1);
    end
    if (len == 0) return;
    if (len > cfg_max_len) begin
      repeat (len) push_item(KIND_BYTE, 8'($urandom()), $urandom(), 1);
      return;
    end
    if (len > space) begin
      for (int r = 0; r <= retries; r++) begin
        repeat (refused) push_item(KIND_BYTE, 8'($urandom()), $urandom(), 0);
        push_item(KIND_RESUME, 8'($urandom()),
                  (r == retries) ? fit_space(len) : short_space(len), 1);
      end
    end
    repeat (len) push_item(KIND_BYTE, 8'($urandom()), $urandom(), 1);
  endtask

  task automatic push_random_frame();
    logic [31:0] len;
    int roll;
    roll = $urandom_range(99);
    if (roll < 8) begin
      len = '0;
    end else if (roll < 25 && cfg_max_len <= 40) begin
      len = cfg_max_len + $urandom_range(1, 6);   // oversized, short discard
    end else if (roll < 33 && cfg_max_len <= 40) begin
      len = cfg_max_len;                          // exactly the maximum
    end else if (roll < 36 && cfg_max_len >= 300) begin
      len = $urandom_range(100, 300);             // a few longer payloads
    end else begin
      len = $urandom_range(1, (cfg_max_len < 16) ? cfg_max_len : 16);
    end
    // stray resume between frames, ignored since nothing is paused
    if ($urandom_range(9) == 0) push_item(KIND_RESUME, 8'($urandom()), $urandom(), 0);
    push_frame(len, ($urandom_range(99) < 60) ? fit_space(len) : short_space(len),
               $urandom_range(3), $urandom_range(2));
  endtask

  task automatic write_reg(logic [0:0] idx, logic [31:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    if (idx == CFG_MAX_LENGTH) cfg_max_len = value;
    else cfg_msb_first = value[0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Every transaction here produces a result, so the block is idle once the
  // last prediction has been matched.
  task automatic wait_drained();
    while (queued_items.size() != 0 || in_valid || pending_results.size() != 0)
      @(negedge clk);
  endtask

  task automatic run_phase(logic [31:0] max_len, logic msb_first, int idle, int stall,
                           logic hold_off);
    int target;
    wait_drained();
    write_reg(CFG_MAX_LENGTH, max_len);
    write_reg(CFG_MSB_FIRST, {31'd0, msb_first});
    @(negedge clk);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    // receiver holds off while the sender keeps offering, so the block fills
    if (hold_off) holds_asked++;
    target = items_queued + PHASE_ITEMS;
    while (items_queued < target) push_random_frame();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part, reset register values first
    push_item(KIND_RESUME, 8'h00, 32'hFFFF_FFFF, 0); // resume with nothing paused
    push_frame(32'd0, $urandom(), 0, 0);             // zero length
    push_frame(32'd1, 32'd1, 0, 0);                  // length equals free space
    push_frame(32'd2, 32'd0, 1, 1);                  // pause, refuse, pause again
    wait_drained();
    write_reg(CFG_MAX_LENGTH, 32'd1);
    write_reg(CFG_MSB_FIRST, 32'd1);
    @(negedge clk);
    push_frame(32'd2, $urandom(), 0, 0);             // one over the maximum
    push_frame(32'd1, 32'hFFFF_FFFF, 0, 0);          // exactly the maximum

    // Random part across register settings and flow-control mixes
    run_phase(32'hFFFF_FFFF, 1'b0, 0, 0, 1'b0);
    run_phase(32'd8, 1'b1, 71, 0, 1'b0);
    run_phase(32'd1, 1'b0, 0, 71, 1'b0);
    run_phase(32'd20, 1'b1, 27, 27, 1'b0);
    run_phase(MAX_LENGTH_RST, 1'b0, 0, 0, 1'b1);
    run_phase($urandom_range(1, 40), 1'($urandom()), 27, 71, 1'b0);

    wait_drained();
    repeat (8) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    if (error_count == 0) begin
      $display("length_prefixed_deframer verification clean");
    end else begin
      $display("length_prefixed_deframer verification failed");
    end
    $finish;
  end

endmodule
